FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Check a property at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

FILE: sv/mac_txt_pkg.sv
// Types and constants of the MAC address text parser.
`timescale 1ns / 1ps
package mac_txt_pkg;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;

  localparam logic [3:0] TOKEN_SAT      = 4'd13;
  localparam logic [3:0] COMPACT_DIGITS = 4'd12;
  localparam logic [3:0] OCTET_DIGITS   = 4'd2;
  localparam logic [2:0] LAST_OCTET     = 3'd5;
  localparam logic [2:0] OCTET_COUNT    = 3'd6;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned OUT_W  = 56;

  typedef enum logic [1:0] {
    SEP_NONE   = 2'd0,
    SEP_COLON  = 2'd1,
    SEP_HYPHEN = 2'd2
  } sep_mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MIXED     = 3'd1,
    ST_COMPACT   = 3'd2,
    ST_BAD_HEX   = 3'd3,
    ST_OCTET_LEN = 3'd4,
    ST_TOO_FEW   = 3'd5,
    ST_TOO_MANY  = 3'd6
  } status_t;

endpackage

FILE: sv/mac_address_text_parser_core.sv
// MAC address text parser: characters in, 48-bit address and status out.
// Result: registered; it appears in the cycle after the end-of-text transaction.
// Throughput: one character per cycle while the result register is free or draining;
// every transaction updates the token state in a single pass, and one output register separates the two sides.
// Reset (rst, synchronous, active high) clears the parse state and drops any
// pending result.
`timescale 1ns / 1ps
module mac_address_text_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [7:0] ch
  input  logic                          s_tlast,  // end_of_text
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mac_txt_pkg::OUT_W-1:0] m_tdata   // [47:0] mac_value, [50:48] status
);
  import mac_txt_pkg::*;

  // Parse state
  sep_mode_t         sep_mode, sep_mode_next;
  logic              mixed_seen, mixed_seen_next;
  logic [3:0]        token_chars, token_chars_next;
  logic              token_bad_hex, token_bad_hex_next;
  logic [2:0]        octet_index, octet_index_next;
  status_t           first_error, first_error_next;
  logic [MAC_W-1:0]  address_shift, address_shift_next;

  // Result register
  logic              out_valid;
  logic [MAC_W-1:0]  out_mac;
  status_t           out_status;

  logic              in_xfer;
  logic              is_sep;
  logic              is_hex;
  logic [3:0]        nibble;
  sep_mode_t         sep_kind;
  status_t           end_status;

  // Error for a token that has just closed; only the first error is kept.
  function automatic status_t close_status(status_t err, logic [3:0] tc, logic bad,
                                           logic [2:0] oi, logic by_sep);
    status_t r;
    r = err;
    if (err == ST_OK) begin
      if (tc != OCTET_DIGITS) r = ST_OCTET_LEN;
      else if (bad) r = ST_BAD_HEX;
      else if (!by_sep && oi < LAST_OCTET) r = ST_TOO_FEW;
      else if (by_sep && oi >= LAST_OCTET) r = ST_TOO_MANY;
    end
    return r;
  endfunction

  // Accept a new transaction whenever the result register is free or draining.
  assign s_tready = !out_valid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // Character classification
  assign is_sep   = (s_tdata == CH_COLON) || (s_tdata == CH_HYPHEN);
  assign sep_kind = (s_tdata == CH_COLON) ? SEP_COLON : SEP_HYPHEN;

  always_comb begin
    case (s_tdata) inside
      [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: is_hex = 1'b1;
      default: is_hex = 1'b0;
    endcase
  end

  // Letters share their low nibble offset: 'a'/'A' have 1 in the low bits.
  assign nibble = !is_hex ? 4'd0 : (s_tdata[6] ? s_tdata[3:0] + 4'd9 : s_tdata[3:0]);

  // Status for the end of text; mixed separators beat every other error.
  always_comb begin
    if (mixed_seen) begin
      end_status = ST_MIXED;
    end else if (sep_mode == SEP_NONE) begin
      if (token_chars != COMPACT_DIGITS) end_status = ST_COMPACT;
      else if (token_bad_hex) end_status = ST_BAD_HEX;
      else end_status = ST_OK;
    end else begin
      end_status = close_status(first_error, token_chars, token_bad_hex, octet_index, 1'b0);
    end
  end

  // Next parse state
  always_comb begin
    sep_mode_next      = sep_mode;
    mixed_seen_next    = mixed_seen;
    token_chars_next   = token_chars;
    token_bad_hex_next = token_bad_hex;
    octet_index_next   = octet_index;
    first_error_next   = first_error;
    address_shift_next = address_shift;
    if (s_tlast) begin
      // End of text: return to the reset state.
      sep_mode_next      = SEP_NONE;
      mixed_seen_next    = 1'b0;
      token_chars_next   = '0;
      token_bad_hex_next = 1'b0;
      octet_index_next   = '0;
      first_error_next   = ST_OK;
      address_shift_next = '0;
    end else if (is_sep) begin
      if (sep_mode == SEP_NONE) sep_mode_next = sep_kind;
      else if (sep_mode != sep_kind) mixed_seen_next = 1'b1;
      first_error_next = close_status(first_error, token_chars, token_bad_hex,
                                      octet_index, 1'b1);
      if (octet_index < OCTET_COUNT) octet_index_next = octet_index + 3'd1;
      token_chars_next   = '0;
      token_bad_hex_next = 1'b0;
    end else begin
      if (!is_hex) token_bad_hex_next = 1'b1;
      if (token_chars < TOKEN_SAT) token_chars_next = token_chars + 4'd1;
      address_shift_next = {address_shift[MAC_W-5:0], nibble};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_mode      <= SEP_NONE;
      mixed_seen    <= 1'b0;
      token_chars   <= '0;
      token_bad_hex <= 1'b0;
      octet_index   <= '0;
      first_error   <= ST_OK;
      address_shift <= '0;
    end else if (in_xfer) begin
      sep_mode      <= sep_mode_next;
      mixed_seen    <= mixed_seen_next;
      token_chars   <= token_chars_next;
      token_bad_hex <= token_bad_hex_next;
      octet_index   <= octet_index_next;
      first_error   <= first_error_next;
      address_shift <= address_shift_next;
    end
  end

  // Result register: load on the end transaction, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && s_tlast) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      out_status <= end_status;
      out_mac    <= (end_status == ST_OK) ? address_shift : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - MAC_W - STAT_W){1'b0}}, out_status, out_mac};

endmodule

FILE: sv/mac_txt_checker.sv
// Port-level checker for the MAC address text parser, bound to the parser core.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mac_txt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mac_txt_pkg::OUT_W-1:0] m_tdata
);
  import mac_txt_pkg::*;

  logic    in_xfer;
  logic    out_blocked;
  status_t res_status;

  assign in_xfer     = s_tvalid && s_tready;
  assign out_blocked = m_tvalid && !m_tready;
  assign res_status  = status_t'(m_tdata[MAC_W+STAT_W-1:MAC_W]);

  `ASSERT_CLK(a_reset_clears_result, clk, rst |=> !m_tvalid)
  `ASSERT_CLK_RST(a_end_gives_result, clk, rst, in_xfer && s_tlast |=> m_tvalid)
  `ASSERT_CLK_RST(a_char_gives_none, clk, rst, in_xfer && !s_tlast && !out_blocked |=> !m_tvalid)
  `ASSERT_CLK_RST(a_error_zero_mac, clk, rst, m_tvalid && res_status != ST_OK |-> m_tdata[MAC_W-1:0] == '0)
  `ASSERT_CLK_RST(a_result_holds, clk, rst, out_blocked |=> m_tvalid && $stable(m_tdata))

endmodule

bind mac_address_text_parser_core mac_txt_checker u_mac_txt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/mac_address_text_parser_core_test.sv
// Self-checking bench for the MAC address text parser core.
`timescale 1ns / 1ps
module mac_address_text_parser_core_test;
  import mac_txt_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int RANDOM_CHARS = 200;
  localparam int TAIL_CHARS = 120;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic [MAC_W-1:0] mac;
    status_t status;
  } addr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  mac_address_text_parser_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Parse state mirrored by the predictor
  sep_mode_t sep_mode;
  bit mixed;
  logic [3:0] token_len;
  bit token_bad;
  logic [2:0] octets;
  status_t first_err;
  logic [MAC_W-1:0] nibbles;

  addr_result_t awaited_addrs[$];
  int mismatches = 0;
  int chars_sent = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_req = 1'b0;

  task automatic report_mismatch(string what, logic [MAC_W-1:0] got, logic [MAC_W-1:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  task automatic clear_parse();
    sep_mode = SEP_NONE;
    mixed = 1'b0;
    token_len = '0;
    token_bad = 1'b0;
    octets = '0;
    first_err = ST_OK;
    nibbles = '0;
  endtask

  // Close one token of the separated form; keep only the first error.
  task automatic close_octet(bit by_sep);
    if (first_err == ST_OK) begin
      if (token_len != OCTET_DIGITS) first_err = ST_OCTET_LEN;
      else if (token_bad) first_err = ST_BAD_HEX;
      else if (!by_sep && octets < LAST_OCTET) first_err = ST_TOO_FEW;
      else if (by_sep && octets >= LAST_OCTET) first_err = ST_TOO_MANY;
    end
    if (octets < OCTET_COUNT) octets++;
    token_len = '0;
    token_bad = 1'b0;
  endtask

  task automatic predict_char(logic [7:0] c, bit last);
    sep_mode_t kind;
    logic [4:0] v;
    addr_result_t res;
    if (!last) begin
      if (c == CH_COLON || c == CH_HYPHEN) begin
        kind = (c == CH_COLON) ? SEP_COLON : SEP_HYPHEN;
        if (sep_mode == SEP_NONE) sep_mode = kind;
        else if (sep_mode != kind) mixed = 1'b1;
        close_octet(1'b1);
      end else begin
        v = digit_value(c);
        if (v[4]) begin
          token_bad = 1'b1;
          v = '0;
        end
        if (token_len < TOKEN_SAT) token_len++;
        nibbles = {nibbles[MAC_W-5:0], v[3:0]};
      end
    end else begin
      // mixed separators win over everything else
      if (mixed) begin
        res.status = ST_MIXED;
      end else if (sep_mode == SEP_NONE) begin
        if (token_len != COMPACT_DIGITS) res.status = ST_COMPACT;
        else if (token_bad) res.status = ST_BAD_HEX;
        else res.status = ST_OK;
      end else begin
        close_octet(1'b0);
        res.status = first_err;
      end
      res.mac = (res.status == ST_OK) ? nibbles : '0;
      awaited_addrs.push_back(res);
      clear_parse();
    end
  endtask

  // Offer one transaction, with an optional idle burst first; predict on acceptance.
  task automatic send_item(logic [7:0] c, bit last);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(char_q_t t);
    foreach (t[i]) send_item(t[i], 1'b0);
    // the character byte is ignored on the closing transaction
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic char_q_t to_chars(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_string(string s);
    send_text(to_chars(s));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (awaited_addrs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(0, 1) != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] random_separator();
    return ($urandom_range(0, 1) != 0) ? CH_COLON : CH_HYPHEN;
  endfunction

  // Mostly well-formed texts with random digits; some damaged, some pure noise.
  task automatic make_random_text(output char_q_t t);
    int form;
    int n;
    int pos;
    logic [7:0] sep;
    t = {};
    form = $urandom_range(0, 9);
    if (form == 0) begin
      n = $urandom_range(0, 20);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0, 1: t.push_back(8'($urandom_range(0, 255)));
          2: t.push_back(random_hex_char());
          default: t.push_back(random_separator());
        endcase
      end
      return;
    end
    if (form <= 3) begin
      repeat (12) t.push_back(random_hex_char());
    end else begin
      sep = (form <= 6) ? CH_COLON : CH_HYPHEN;
      for (int k = 0; k < 6; k++) begin
        if (k != 0) t.push_back(sep);
        t.push_back(random_hex_char());
        t.push_back(random_hex_char());
      end
    end
    if ($urandom_range(0, 2) != 0) return;
    pos = $urandom_range(0, t.size() - 1);
    case ($urandom_range(0, 5))
      0: t[pos] = 8'($urandom_range(0, 255));
      1: t.delete(pos);
      2: t.insert($urandom_range(0, t.size()),
                  ($urandom_range(0, 1) != 0) ? random_hex_char() : random_separator());
      3: begin
        if (t[pos] == CH_COLON) t[pos] = CH_HYPHEN;
        else if (t[pos] == CH_HYPHEN) t[pos] = CH_COLON;
        else t[pos] = random_separator();
      end
      4: begin
        t.push_back((form <= 3) ? random_separator() : sep);
        t.push_back(random_hex_char());
        t.push_back(random_hex_char());
      end
      default: begin
        n = $urandom_range(0, t.size() - 1);
        while (t.size() > n) void'(t.pop_back());
      end
    endcase
  endtask

  task automatic test_good_forms();
    send_string("001122AABBCC");
    send_string("ffffffffffff");
    send_string("00:00:00:00:00:00");
    send_string("FF-ff-Fe-eF-a9-0B");
  endtask

  task automatic test_compact_errors();
    char_q_t t;
    send_string("");
    send_string("0123456789a");
    send_string("0123456789abcdef");  // saturating length
    send_string("01234567890g");
    t = to_chars("0123456789ab");
    t[2] = 8'hC1;
    t[7] = 8'h00;
    t[9] = 8'hFF;
    send_text(t);
  endtask

  task automatic test_separator_errors();
    send_string("01:23-45:67:89:ab");
    send_string("0x-23:45:67:89:a");  // mixed beats bad hex and length
    send_string(":");
    send_string("-");
  endtask

  task automatic test_octet_errors();
    char_q_t t;
    send_string("01:2:34:56:78:9a");
    send_string("01:23:4g:56:78:9a");
    send_string("01:234:56:78:9a:bc");
    send_string("01-23-45-67-89");
    send_string("01:23:45:67:89:ab:cd");
    send_string("01-23-45-67-89-ab-");
    t = to_chars("01:23:45:67:89:ab");
    t[15] = 8'h80;
    send_text(t);
  endtask

  task automatic test_random_texts(int budget);
    char_q_t t;
    int stop_at;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      make_random_text(t);
      send_text(t);
    end
  endtask

  // Hold the receiver off while streaming texts so the core stalls its input.
  task automatic test_output_hold();
    char_q_t t;
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (8) begin
      t = {};
      repeat (12) t.push_back(random_hex_char());
      send_text(t);
    end
    src_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    test_random_texts(40);
    wait_for_results();
    repeat ($urandom_range(1, 10)) @(posedge clk);
    test_random_texts(40);
  endtask

  task automatic test_steady_stream();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    test_random_texts(TAIL_CHARS);
  endtask

  // Receiver: ready bursts, random stalls, and one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    addr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_addrs.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[MAC_W-1:0], '0);
      end else begin
        want = awaited_addrs.pop_front();
        if (m_tdata[MAC_W-1:0] !== want.mac)
          report_mismatch("mac_value", m_tdata[MAC_W-1:0], want.mac);
        if (m_tdata[MAC_W+STAT_W-1:MAC_W] !== want.status)
          report_mismatch("status", 48'(m_tdata[MAC_W+STAT_W-1:MAC_W]), 48'(want.status));
      end
    end
  end

  // Abort when neither side has moved a transaction for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_good_forms();
    test_compact_errors();
    test_separator_errors();
    test_octet_errors();
    test_random_texts(RANDOM_CHARS);
    test_output_hold();
    test_drain_pause();
    test_steady_stream();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
